/* src/wpm_pkg.sv */
package wpm_pkg;

  localparam int MAX_PATTERN_DEFAULT = 64;

  localparam logic [7:0] STAR_CHAR     = 8'd42;
  localparam logic [7:0] QUESTION_CHAR = 8'd63;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_TEXT   = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  // One text byte travelling along the row of cells, with the old and new
  // match bits of the cell it has just left.
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
    logic       old_bit;
    logic       new_bit;
  } wave_t;

  typedef struct packed {
    logic       clear;
    logic       restore;
    logic [7:0] chr;
  } cell_ctrl_t;

endpackage

/* src/wildcard_pattern_matcher_top.sv */
// Channel   Handshake                  Payload
// item      item_valid / item_stall    kind, character
// result    result_valid / result_stall  matched, pattern_overflow
//
// A text beat is taken every cycle; its byte moves one cell a cycle along
// the row, so several text bytes are in flight at once.
// Append, clear and finish beats wait until the row has drained: they are
// stalled until the last text byte has passed every cell of the row,
// whatever the pattern length.
// A finish beat also waits while a stalled result is held.
// Reset empties the pattern and the row; the result register holds one beat.
module wildcard_pattern_matcher_top
  import wpm_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] kind,
  input  logic [7:0] character,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       matched,
  output logic       pattern_overflow
);

  localparam int LW = $clog2(MAX_PATTERN + 1);

  logic [LW-1:0]      length;
  logic               overflow;
  logic               match0;
  logic               accept;
  logic               busy;
  logic               full;
  logic               is_text;
  logic               is_append;
  logic               is_finish;
  logic               is_clear;
  cell_ctrl_t         ctrl;
  wave_t              link [MAX_PATTERN+1];
  logic [MAX_PATTERN:0] init_row;
  logic [MAX_PATTERN:0] row;
  logic [MAX_PATTERN:1] in_flight;

  assign is_text   = (kind_t'(kind) == KIND_TEXT);
  assign is_append = (kind_t'(kind) == KIND_APPEND);
  assign is_finish = (kind_t'(kind) == KIND_FINISH);
  assign is_clear  = (kind_t'(kind) == KIND_CLEAR);

  assign busy       = |in_flight;
  assign full       = (length == LW'(MAX_PATTERN));
  assign item_stall = (!is_text && busy) || (is_finish && result_valid && result_stall);
  assign accept     = item_valid && !item_stall;

  assign ctrl.clear   = accept && is_clear;
  assign ctrl.restore = accept && (is_append || is_finish);
  assign ctrl.chr     = character;

  assign link[0].valid   = accept && is_text;
  assign link[0].ch      = character;
  assign link[0].old_bit = match0;
  assign link[0].new_bit = 1'b0;

  assign init_row[0] = 1'b1;
  assign row[0]      = match0;

  for (genvar j = 1; j <= MAX_PATTERN; j++) begin : g_cell
    logic load;
    assign load         = accept && is_append && !full && (length == LW'(j - 1));
    assign in_flight[j] = link[j].valid;

    wpm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .load      (load),
      .init_left (init_row[j-1]),
      .init_bit  (init_row[j]),
      .match_bit (row[j]),
      .wave_in   (link[j-1]),
      .wave_out  (link[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length   <= '0;
      overflow <= 1'b0;
      match0   <= 1'b1;
    end else if (accept) begin
      if (is_clear) begin
        length   <= '0;
        overflow <= 1'b0;
        match0   <= 1'b1;
      end else if (is_append) begin
        match0 <= 1'b1;
        if (full) begin
          overflow <= 1'b1;
        end else begin
          length <= length + LW'(1);
        end
      end else if (is_finish) begin
        match0 <= 1'b1;
      end else begin
        match0 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && is_finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_finish) begin
      matched          <= row[length];
      pattern_overflow <= overflow;
    end
  end

endmodule

/* src/wpm_cell.sv */
module wpm_cell
  import wpm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       load,
  input  logic       init_left,
  output logic       init_bit,
  output logic       match_bit,
  input  wave_t      wave_in,
  output wave_t      wave_out
);

  logic [7:0] pchar;
  logic       active;
  logic       init;
  logic       match;
  logic       match_new;
  logic       init_load;

  assign init_bit  = init;
  assign match_bit = match;
  assign init_load = init_left && (ctrl.chr == STAR_CHAR);

  // The exact comparison is tested before the wildcards, so a text star
  // against a pattern star counts as a literal match.
  always_comb begin
    if (!active) begin
      match_new = 1'b0;
    end else if ((wave_in.ch == pchar) || (pchar == QUESTION_CHAR)) begin
      match_new = wave_in.old_bit;
    end else if (pchar == STAR_CHAR) begin
      match_new = wave_in.new_bit || match;
    end else begin
      match_new = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pchar <= ctrl.chr;
    end
    wave_out.ch      <= wave_in.ch;
    wave_out.old_bit <= match;
    wave_out.new_bit <= match_new;
    if (rst) begin
      active         <= 1'b0;
      init           <= 1'b0;
      match          <= 1'b0;
      wave_out.valid <= 1'b0;
    end else begin
      wave_out.valid <= wave_in.valid;
      if (ctrl.clear) begin
        active <= 1'b0;
        init   <= 1'b0;
        match  <= 1'b0;
      end else if (load) begin
        active <= 1'b1;
        init   <= init_load;
        match  <= init_load;
      end else if (ctrl.restore) begin
        match <= init;
      end else if (wave_in.valid) begin
        match <= match_new;
      end
    end
  end

endmodule

/* tb/wildcard_pattern_matcher_top_tb.sv */
`timescale 1ns / 1ps

module wildcard_pattern_matcher_top_tb;
  import wpm_pkg::*;

  localparam int MAX_PAT = MAX_PATTERN_DEFAULT;
  localparam int STALL_PCT = 36;
  localparam int HANG_LIMIT = 2000;
  localparam int ITEM_COUNT = 1000;

  typedef struct {
    bit matched;
    bit overflow;
  } verdict_t;

  // Tracks the pattern and the match row as the block should, and holds the
  // verdicts that finish beats still owe.
  class match_scoreboard;
    logic [7:0] pattern [MAX_PAT];
    int unsigned pat_len;
    bit [MAX_PAT:0] row;
    bit [MAX_PAT:0] start_row;
    bit overflow;
    verdict_t verdicts_due [$];
    int unsigned errors;
    int unsigned results;
    int unsigned match_count;
    int unsigned overflows;

    function new();
      errors = 0;
      results = 0;
      match_count = 0;
      overflows = 0;
      clear_pattern();
    endfunction

    function void clear_pattern();
      pat_len = 0;
      start_row = '0;
      start_row[0] = 1'b1;
      overflow = 1'b0;
      row = start_row;
    endfunction

    function void step_text(logic [7:0] c);
      bit [MAX_PAT:0] nxt;
      logic [7:0] p;
      nxt = '0;
      for (int j = 1; j <= pat_len; j++) begin
        p = pattern[j-1];
        // Equality is tested first, so a text star meets a pattern star as a literal.
        if (c == p || p == QUESTION_CHAR) begin
          nxt[j] = row[j-1];
        end else if (p == STAR_CHAR) begin
          nxt[j] = nxt[j-1] | row[j];
        end else begin
          nxt[j] = 1'b0;
        end
      end
      row = nxt;
    endfunction

    function void note_item(kind_t k, logic [7:0] c);
      verdict_t v;
      case (k)
        KIND_APPEND: begin
          if (pat_len >= MAX_PAT) begin
            overflow = 1'b1;
          end else begin
            pattern[pat_len] = c;
            start_row[pat_len+1] = start_row[pat_len] && (c == STAR_CHAR);
            pat_len++;
          end
          row = start_row;
        end
        KIND_TEXT: step_text(c);
        KIND_FINISH: begin
          v.matched = row[pat_len];
          v.overflow = overflow;
          verdicts_due.push_back(v);
          row = start_row;
        end
        default: clear_pattern();
      endcase
    endfunction

    function void check_result(bit m, bit o);
      verdict_t v;
      results++;
      if (verdicts_due.size() == 0) begin
        $display("%0t: result beat with nothing expected (matched %0b, overflow %0b)",
                 $time, m, o);
        errors++;
        return;
      end
      v = verdicts_due.pop_front();
      if (m != v.matched) begin
        $display("%0t: matched expected %0b, got %0b", $time, v.matched, m);
        errors++;
      end
      if (o != v.overflow) begin
        $display("%0t: pattern_overflow expected %0b, got %0b", $time, v.overflow, o);
        errors++;
      end
      match_count += m;
      overflows += o;
    endfunction

    function int unsigned pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  logic [1:0] kind;
  logic [7:0] character;
  logic result_valid;
  logic result_stall;
  logic matched;
  logic pattern_overflow;

  match_scoreboard sb;
  bit idle_on;
  int unsigned items_sent;
  int unsigned quiet_cycles;
  logic [7:0] cur_pat [$];

  wildcard_pattern_matcher_top dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .kind(kind),
    .character(character),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .matched(matched),
    .pattern_overflow(pattern_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) begin
      sb.note_item(kind_t'(kind), character);
    end
    if (!rst && result_valid && !result_stall) begin
      sb.check_result(matched, pattern_overflow);
    end
  end

  always @(posedge clk) begin
    result_stall <= idle_on && ($urandom_range(0, 99) < STALL_PCT);
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles, %0d verdicts outstanding",
               $time, HANG_LIMIT, sb.pending());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return STAR_CHAR;
      1: return QUESTION_CHAR;
      2, 3, 4: return 8'h61 + 8'($urandom_range(0, 2));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_pat_byte();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: return STAR_CHAR;
      5, 6, 7, 8: return QUESTION_CHAR;
      9, 10, 11, 12, 13, 14, 15: return 8'h61 + 8'($urandom_range(0, 2));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_item(input kind_t k, input logic [7:0] c);
    // A stretch in the middle of the random part runs with no idling on either side.
    idle_on = !(items_sent >= 450 && items_sent < 650);
    while (idle_on && $urandom_range(0, 99) < STALL_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    kind <= k;
    character <= c;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
    if (k == KIND_CLEAR) begin
      cur_pat.delete();
    end else if (k == KIND_APPEND && cur_pat.size() < MAX_PAT) begin
      cur_pat.push_back(c);
    end
  endtask

  task automatic send_pattern();
    int unsigned len;
    if ($urandom_range(0, 99) < 80) send_item(KIND_CLEAR, 8'($urandom_range(0, 255)));
    len = ($urandom_range(0, 99) < 5) ? $urandom_range(50, 70) : $urandom_range(0, 6);
    repeat (len) send_item(KIND_APPEND, pick_pat_byte());
  endtask

  // Mostly texts spelt out from the current pattern so that matches are common,
  // some with one byte spoilt, the rest free-form.
  task automatic send_text();
    logic [7:0] txt [$];
    int unsigned pos;
    if ($urandom_range(0, 99) < 70) begin
      foreach (cur_pat[i]) begin
        if (cur_pat[i] == STAR_CHAR) begin
          repeat ($urandom_range(0, 3)) txt.push_back(pick_byte());
        end else if (cur_pat[i] == QUESTION_CHAR) begin
          txt.push_back(8'($urandom_range(0, 255)));
        end else begin
          txt.push_back(cur_pat[i]);
        end
      end
      if (txt.size() != 0 && $urandom_range(0, 99) < 25) begin
        pos = $urandom_range(0, txt.size() - 1);
        txt[pos] = pick_byte();
      end
    end else begin
      repeat ($urandom_range(0, 10)) txt.push_back(pick_byte());
    end
    foreach (txt[i]) begin
      // Now and then an append lands mid-text and abandons it.
      if ($urandom_range(0, 99) < 2) send_item(KIND_APPEND, pick_pat_byte());
      send_item(KIND_TEXT, txt[i]);
    end
    send_item(KIND_FINISH, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    sb = new();
    idle_on = 1'b1;
    items_sent = 0;
    quiet_cycles = 0;
    rst <= 1'b1;
    item_valid <= 1'b0;
    kind <= KIND_CLEAR;
    character <= 8'h00;
    result_stall <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Empty pattern against empty and non-empty text.
    send_item(KIND_FINISH, 8'hFF);
    send_item(KIND_TEXT, 8'h61);
    send_item(KIND_FINISH, 8'h00);
    // A lone star matches the empty text and a star in the text as a literal.
    send_item(KIND_APPEND, STAR_CHAR);
    send_item(KIND_FINISH, 8'h55);
    send_item(KIND_TEXT, STAR_CHAR);
    send_item(KIND_TEXT, 8'h00);
    send_item(KIND_FINISH, 8'hAA);
    // Pattern "*?a": question mark against a question mark and against any byte.
    send_item(KIND_APPEND, QUESTION_CHAR);
    send_item(KIND_APPEND, 8'h61);
    send_item(KIND_TEXT, 8'hFF);
    send_item(KIND_TEXT, QUESTION_CHAR);
    send_item(KIND_TEXT, 8'h61);
    send_item(KIND_FINISH, 8'h00);
    send_item(KIND_TEXT, 8'h61);
    send_item(KIND_FINISH, 8'h00);
    // An append in the middle of a text abandons it.
    send_item(KIND_TEXT, 8'h7A);
    send_item(KIND_APPEND, 8'h80);
    send_item(KIND_TEXT, 8'h80);
    send_item(KIND_TEXT, 8'h61);
    send_item(KIND_TEXT, 8'h80);
    send_item(KIND_FINISH, 8'h00);
    // A clear in the middle of a text.
    send_item(KIND_TEXT, 8'h61);
    send_item(KIND_CLEAR, 8'hFF);
    send_item(KIND_FINISH, 8'h00);

    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);

    while (items_sent < ITEM_COUNT) begin
      if ($urandom_range(0, 99) < 85) begin
        send_pattern();
        repeat ($urandom_range(1, 4)) send_text();
      end else begin
        repeat ($urandom_range(1, 5)) begin
          send_item(kind_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
      end
    end
    item_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (MAX_PAT + 16) @(posedge clk);

    $display("Sent %0d item beats; checked %0d verdicts, %0d of them matches,",
             items_sent, sb.results, sb.match_count);
    $display("%0d of them with the pattern overflow flag set.", sb.overflows);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
